### design/wide_unsigned_divider_assert.svh
// ----------------------------------------------------------------------------
// wide_unsigned_divider_assert.svh
// assertion macros shared by the divider checker
// ----------------------------------------------------------------------------
`ifndef WIDE_UNSIGNED_DIVIDER_ASSERT_SVH
`define WIDE_UNSIGNED_DIVIDER_ASSERT_SVH

// same-cycle implication
`define WUD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WUD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/wud_pkg.sv
// ----------------------------------------------------------------------------
// wud_pkg
// shared constants and types of the wide unsigned divider
// ----------------------------------------------------------------------------
`default_nettype none

package wud_pkg;

   localparam int WORD_COUNT  = 8;
   localparam int WORD_BITS   = 32;
   localparam int TOTAL_BITS  = WORD_COUNT * WORD_BITS;
   localparam int IDX_BITS    = $clog2(WORD_COUNT);
   localparam int CNT_BITS    = $clog2(TOTAL_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic zero_div;
   } job_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      job_type head;
   } queue_status_type;

endpackage

`default_nettype wire

### design/wud_queue.sv
// ----------------------------------------------------------------------------
// wud_queue
// short job queue between the load front and the divide back
// ----------------------------------------------------------------------------
`default_nettype none

module wud_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire wud_pkg::job_type          push_job,
   input  wire logic                      pop,
   output wud_pkg::queue_status_type      status
);

   wud_pkg::job_type                 mem_ff [wud_pkg::QUEUE_DEPTH];
   logic [wud_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [wud_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [wud_pkg::QPTR_BITS:0]      count_ff, count_in;
   logic                             do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (wud_pkg::QPTR_BITS+1)'(wud_pkg::QUEUE_DEPTH));
   assign status.head  = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == wud_pkg::QPTR_BITS'(wud_pkg::QUEUE_DEPTH-1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == wud_pkg::QPTR_BITS'(wud_pkg::QUEUE_DEPTH-1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### design/wud_front.sv
// ----------------------------------------------------------------------------
// wud_front
// takes load words into the operand stores and queues a job on the last one
// ----------------------------------------------------------------------------
`default_nettype none

module wud_front (
   input  wire logic                      clock,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [31:0]               req_dividend_word,
   input  wire logic [31:0]               req_divisor_word,
   input  wire logic [2:0]                req_word_index,
   input  wire logic                      req_last_word,
   input  wire wud_pkg::queue_status_type q_status,
   output logic                           push,
   output wud_pkg::job_type               push_job,
   output wud_pkg::word_type              dividend_words [wud_pkg::WORD_COUNT],
   output wud_pkg::word_type              divisor_words  [wud_pkg::WORD_COUNT]
);

   wud_pkg::word_type             dvd_ff [wud_pkg::WORD_COUNT];
   wud_pkg::word_type             dvs_ff [wud_pkg::WORD_COUNT];
   logic                          accept;
   logic                          idx_ok;
   logic [wud_pkg::IDX_BITS-1:0]  idx;
   logic                          any_div;

   // hold loads while a job waits, the back copies the stores when it starts
   assign req_stall = !q_status.empty;
   assign accept    = req_valid && !req_stall;
   assign idx_ok    = ({1'b0, req_word_index} < 4'(wud_pkg::WORD_COUNT));
   assign idx       = req_word_index[wud_pkg::IDX_BITS-1:0];

   // divisor zero test sees the word written by this item
   always_comb begin
      any_div = 1'b0;
      for (int i = 0; i < wud_pkg::WORD_COUNT; i++) begin
         if (idx_ok && (idx == wud_pkg::IDX_BITS'(i))) begin
            any_div = any_div | (|req_divisor_word);
         end else begin
            any_div = any_div | (|dvs_ff[i]);
         end
      end
   end

   assign push              = accept && req_last_word;
   assign push_job.zero_div = !any_div;

   always_ff @(posedge clock) begin
      if (accept && idx_ok) begin
         dvd_ff[idx] <= req_dividend_word;
         dvs_ff[idx] <= req_divisor_word;
      end
   end

   assign dividend_words = dvd_ff;
   assign divisor_words  = dvs_ff;

endmodule

`default_nettype wire

### design/wud_back.sv
// ----------------------------------------------------------------------------
// wud_back
// restoring divide, one quotient bit per cycle, then emits quotient words
// ----------------------------------------------------------------------------
`default_nettype none

module wud_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wud_pkg::queue_status_type q_status,
   output logic                           pop,
   input  wire wud_pkg::word_type         dividend_words [wud_pkg::WORD_COUNT],
   input  wire wud_pkg::word_type         divisor_words  [wud_pkg::WORD_COUNT],
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [31:0]                    rsp_quotient_word,
   output logic [2:0]                     rsp_out_index,
   output logic                           rsp_final_word,
   output logic                           rsp_divide_by_zero
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   state_type                          state_ff;
   logic [wud_pkg::TOTAL_BITS-1:0]     num_ff;
   logic [wud_pkg::TOTAL_BITS-1:0]     div_ff;
   logic [wud_pkg::TOTAL_BITS-1:0]     rem_ff;
   logic [wud_pkg::CNT_BITS-1:0]       cnt_ff;
   logic [wud_pkg::IDX_BITS-1:0]       out_cnt_ff;
   logic                               zero_ff;
   logic                               rsp_valid_ff;
   logic [31:0]                        rsp_word_ff;
   logic [2:0]                         rsp_index_ff;
   logic                               rsp_final_ff;
   logic                               rsp_zero_ff;

   logic [wud_pkg::TOTAL_BITS-1:0]     dvd_flat, dvs_flat;
   logic [wud_pkg::TOTAL_BITS:0]       shifted;
   logic [wud_pkg::TOTAL_BITS+1:0]     diff;
   logic                               take;
   logic                               out_free;

   always_comb begin
      for (int i = 0; i < wud_pkg::WORD_COUNT; i++) begin
         dvd_flat[i*wud_pkg::WORD_BITS +: wud_pkg::WORD_BITS] = dividend_words[i];
         dvs_flat[i*wud_pkg::WORD_BITS +: wud_pkg::WORD_BITS] = divisor_words[i];
      end
   end

   // shift in the next dividend bit, subtract when it fits
   assign shifted  = {rem_ff, num_ff[wud_pkg::TOTAL_BITS-1]};
   assign diff     = {1'b0, shifted} - {2'b00, div_ff};
   assign take     = !diff[wud_pkg::TOTAL_BITS+1];
   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         out_cnt_ff   <= '0;
      end else begin
         if ((state_ff == ST_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  zero_ff    <= q_status.head.zero_div;
                  num_ff     <= q_status.head.zero_div ? '0 : dvd_flat;
                  div_ff     <= dvs_flat;
                  rem_ff     <= '0;
                  cnt_ff     <= wud_pkg::CNT_BITS'(wud_pkg::TOTAL_BITS-1);
                  out_cnt_ff <= '0;
                  state_ff   <= q_status.head.zero_div ? ST_EMIT : ST_RUN;
               end
            end
            ST_RUN: begin
               rem_ff <= take ? diff[wud_pkg::TOTAL_BITS-1:0]
                              : shifted[wud_pkg::TOTAL_BITS-1:0];
               num_ff <= {num_ff[wud_pkg::TOTAL_BITS-2:0], take};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_word_ff  <= num_ff[wud_pkg::WORD_BITS-1:0];
                  rsp_index_ff <= 3'(out_cnt_ff);
                  rsp_final_ff <= (out_cnt_ff == wud_pkg::IDX_BITS'(wud_pkg::WORD_COUNT-1));
                  rsp_zero_ff  <= zero_ff;
                  num_ff       <= num_ff >> wud_pkg::WORD_BITS;
                  out_cnt_ff   <= out_cnt_ff + 1'b1;
                  if (out_cnt_ff == wud_pkg::IDX_BITS'(wud_pkg::WORD_COUNT-1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient_word  = rsp_word_ff;
   assign rsp_out_index      = rsp_index_ff;
   assign rsp_final_word     = rsp_final_ff;
   assign rsp_divide_by_zero = rsp_zero_ff;

endmodule

`default_nettype wire

### design/wide_unsigned_divider.sv
// the last load word queues a job; a zero divisor skips the divide loop
// the 256-bit subtract loop retires one quotient bit per cycle
// quotient words then leave one per cycle, if not stalled, via a single output register
// the load words of the next division overlap the divide
// reset is synchronous active high, clears control only, the operand stores keep junk
// ----------------------------------------------------------------------------
// wide_unsigned_divider
// 256-bit unsigned divider, word loads in, quotient words out
// ----------------------------------------------------------------------------
`default_nettype none

module wide_unsigned_divider (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [31:0]  req_dividend_word,
   input  wire logic [31:0]  req_divisor_word,
   input  wire logic [2:0]   req_word_index,
   input  wire logic         req_last_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [31:0]       rsp_quotient_word,
   output logic [2:0]        rsp_out_index,
   output logic              rsp_final_word,
   output logic              rsp_divide_by_zero
);

   wud_pkg::queue_status_type q_status;
   wud_pkg::job_type          push_job;
   logic                      push;
   logic                      pop;
   wud_pkg::word_type         dividend_words [wud_pkg::WORD_COUNT];
   wud_pkg::word_type         divisor_words  [wud_pkg::WORD_COUNT];

   wud_front u_front (
      .clock             (clock),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dividend_word (req_dividend_word),
      .req_divisor_word  (req_divisor_word),
      .req_word_index    (req_word_index),
      .req_last_word     (req_last_word),
      .q_status          (q_status),
      .push              (push),
      .push_job          (push_job),
      .dividend_words    (dividend_words),
      .divisor_words     (divisor_words)
   );

   wud_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .status   (q_status)
   );

   wud_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .pop                (pop),
      .dividend_words     (dividend_words),
      .divisor_words      (divisor_words),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient_word  (rsp_quotient_word),
      .rsp_out_index      (rsp_out_index),
      .rsp_final_word     (rsp_final_word),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

`default_nettype wire

### design/wud_checker.sv
// ----------------------------------------------------------------------------
// wud_checker
// port-level checks on the divider result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "wide_unsigned_divider_assert.svh"

module wud_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic [31:0]  req_dividend_word,
   input wire logic [31:0]  req_divisor_word,
   input wire logic [2:0]   req_word_index,
   input wire logic         req_last_word,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic [31:0]  rsp_quotient_word,
   input wire logic [2:0]   rsp_out_index,
   input wire logic         rsp_final_word,
   input wire logic         rsp_divide_by_zero
);

   `WUD_ASSERT_NOW(a_zero_div_quotient, rsp_valid && rsp_divide_by_zero, rsp_quotient_word == 32'd0, "quotient not zero on divide by zero")
   `WUD_ASSERT_NOW(a_final_index, rsp_valid && rsp_final_word, rsp_out_index == 3'(wud_pkg::WORD_COUNT-1), "final word not at top index")
   `WUD_ASSERT_NEXT(a_index_step, rsp_valid && !rsp_stall && !rsp_final_word, rsp_valid && (rsp_out_index == 3'($past(rsp_out_index) + 3'd1)), "quotient words not in order")
   `WUD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_quotient_word) && $stable(rsp_out_index), "stalled result changed")

endmodule

bind wide_unsigned_divider wud_checker u_wud_checker (.*);

`default_nettype wire
